// ----- hw/rtl/timestamp_column_search_core_assert.svh -----
// Assertion macros for the timestamp column search core top level
`ifndef TIMESTAMP_COLUMN_SEARCH_CORE_ASSERT_SVH
`define TIMESTAMP_COLUMN_SEARCH_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication
`define TCS_ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("timestamp column search assertion failed");
// Next-cycle implication
`define TCS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("timestamp column search assertion failed");
`else
`define TCS_ASSERT_IMPLIES(lbl, clk, rst, ante, cons)
`define TCS_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

// ----- hw/rtl/tcs_pkg.sv -----
// Shared constants, codes and controller/datapath interface types
`timescale 1ns / 1ps
package tcs_pkg;

   localparam int DEPTH       = 1024;
   localparam int NARROW_BITS = 32;
   localparam int TIME_W      = 64;
   localparam int POS_W       = 10;
   localparam int IDX_W       = 11;
   localparam int FUNC_W      = 2;
   localparam int STATUS_W    = 2;
   localparam int ADDR_W      = $clog2(DEPTH);
   localparam int CNT_W       = ADDR_W + 1;
   localparam int REQ_DATA_W  = ((TIME_W + POS_W + 7) / 8) * 8;
   localparam int RSP_DATA_W  = ((TIME_W + IDX_W + 7) / 8) * 8;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_APPEND = 2'd0,
      FUNC_READ   = 2'd1,
      FUNC_UPPER  = 2'd2,
      FUNC_LOWER  = 2'd3
   } func_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK       = 2'd0,
      ST_FULL     = 2'd1,
      ST_PAST_END = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_READ_WAIT,
      S_SEARCH,
      S_PROMOTE_RD,
      S_PROMOTE_WR,
      S_APPEND_WIDE,
      S_DONE
   } state_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_APPEND_FIRST,
      OP_APPEND_NARROW,
      OP_APPEND_WIDE,
      OP_READ_ISSUE,
      OP_SEARCH_START,
      OP_SEARCH_STEP,
      OP_PROMOTE_RD,
      OP_PROMOTE_WR
   } op_type;

   typedef enum logic [2:0] {
      RES_OK,
      RES_FULL,
      RES_PAST_END,
      RES_READ,
      RES_BOUND,
      RES_COUNT
   } res_type;

   typedef struct packed {
      logic    load_req;
      op_type  op;
      logic    res_load;
      res_type res_sel;
      logic    out_load;
   } cmd_type;

   typedef struct packed {
      func_type         func;
      logic             full;
      logic             wide;
      logic             count_zero;
      logic             pos_valid;
      logic             below_strict;
      logic             below_eq;
      logic             over;
      logic             step_last;
      logic             promote_last;
      logic [CNT_W-1:0] count;
   } stat_type;

endpackage

// ----- hw/rtl/timestamp_column_search_core.sv -----
// Top level of the timestamp column search core: controller, datapath, assertions
//
//  channel | dir | handshake                 | payload
//  --------+-----+---------------------------+---------------------------------------------
//  req     | in  | req_tvalid / req_tready   | tuser: func; tdata: time_value, position
//  rsp     | out | rsp_tvalid / rsp_tready   | tuser: status; tdata: result_time, result_index
//  csr     | in  | csr_valid / csr_ready     | csr_wdata: empty_marker
//
// One transaction at a time. An append passes through decode and done; an in-range read adds a
// RAM wait state, and the early-out searches go straight from decode to done; a binary search
// does one registered RAM read per halving step.
// The append that promotes the store walks it first, reading and then writing each stored entry.
// Synchronous active-high reset empties the store and sets empty_marker to all ones.
// A result waits in the output register while the next request is taken and worked.
`timescale 1ns / 1ps
`include "timestamp_column_search_core_assert.svh"
module timestamp_column_search_core (
   input  logic                           clock,
   input  logic                           reset,
   // request channel
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [tcs_pkg::REQ_DATA_W-1:0] req_tdata,  // time_value[63:0], position[73:64]
   input  logic [tcs_pkg::FUNC_W-1:0]     req_tuser,  // func[1:0]
   // response channel
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [tcs_pkg::RSP_DATA_W-1:0] rsp_tdata,  // result_time[63:0], result_index[74:64]
   output logic [tcs_pkg::STATUS_W-1:0]   rsp_tuser,  // status[1:0]
   // configuration write channel
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [tcs_pkg::TIME_W-1:0]     csr_wdata
);

   tcs_pkg::cmd_type  cmd;
   tcs_pkg::stat_type stat;

   // marker register is always writable; the host must change it only between transactions (not enforced here)
   assign csr_ready = 1'b1;

   tcs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   tcs_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .csr_write (csr_valid & csr_ready),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

   // hold off further requests while one is in flight
   `TCS_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_tvalid && req_tready, !req_tready)
   // wide mode never drops back to narrow without reset
   `TCS_ASSERT_NEXT(a_wide_sticky, clock, reset, stat.wide, stat.wide)
   // entry count never passes the store depth
   `TCS_ASSERT_IMPLIES(a_count_bound, clock, reset, 1'b1,
                       stat.count <= tcs_pkg::CNT_W'(tcs_pkg::DEPTH))
   // a full store never reports the empty state
   `TCS_ASSERT_IMPLIES(a_full_not_empty, clock, reset, stat.full, !stat.count_zero)

endmodule

// ----- hw/rtl/tcs_ram.sv -----
// Generic single-write, single-read RAM with registered read data
`timescale 1ns / 1ps
module tcs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/tcs_ctrl.sv -----
// Controller state machine: sequences appends, reads, searches and promotion
`timescale 1ns / 1ps
module tcs_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   input  tcs_pkg::stat_type stat,
   output tcs_pkg::cmd_type  cmd
);

   tcs_pkg::state_type state_ff;
   tcs_pkg::state_type state_in;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   logic               zero_hit;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tcs_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // narrow-mode key below the base (at or below it for a lower-bound search) ends the search at index zero
   assign zero_hit = (stat.func == tcs_pkg::FUNC_UPPER) ? stat.below_strict : stat.below_eq;

   always_comb begin
      cmd        = '0;
      cmd.op     = tcs_pkg::OP_NONE;
      cmd.res_sel = tcs_pkg::RES_OK;
      state_in   = state_ff;
      req_tready = 1'b0;
      unique case (state_ff)
         tcs_pkg::S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load_req = 1'b1;
               state_in     = tcs_pkg::S_DECODE;
            end
         end
         tcs_pkg::S_DECODE: begin
            unique case (stat.func)
               tcs_pkg::FUNC_APPEND: begin
                  priority if (stat.full) begin
                     cmd.res_load = 1'b1;
                     cmd.res_sel  = tcs_pkg::RES_FULL;
                     state_in     = tcs_pkg::S_DONE;
                  end else if (stat.wide) begin
                     cmd.op       = tcs_pkg::OP_APPEND_WIDE;
                     cmd.res_load = 1'b1;
                     state_in     = tcs_pkg::S_DONE;
                  end else if (stat.count_zero) begin
                     cmd.op       = tcs_pkg::OP_APPEND_FIRST;
                     cmd.res_load = 1'b1;
                     state_in     = tcs_pkg::S_DONE;
                  end else if (stat.below_strict || stat.over) begin
                     state_in = tcs_pkg::S_PROMOTE_RD;
                  end else begin
                     cmd.op       = tcs_pkg::OP_APPEND_NARROW;
                     cmd.res_load = 1'b1;
                     state_in     = tcs_pkg::S_DONE;
                  end
               end
               tcs_pkg::FUNC_READ: begin
                  if (stat.pos_valid) begin
                     cmd.op   = tcs_pkg::OP_READ_ISSUE;
                     state_in = tcs_pkg::S_READ_WAIT;
                  end else begin
                     cmd.res_load = 1'b1;
                     cmd.res_sel  = tcs_pkg::RES_PAST_END;
                     state_in     = tcs_pkg::S_DONE;
                  end
               end
               tcs_pkg::FUNC_UPPER, tcs_pkg::FUNC_LOWER: begin
                  priority if (stat.count_zero) begin
                     cmd.res_load = 1'b1;
                     state_in     = tcs_pkg::S_DONE;
                  end else if (stat.wide) begin
                     cmd.op   = tcs_pkg::OP_SEARCH_START;
                     state_in = tcs_pkg::S_SEARCH;
                  end else if (zero_hit) begin
                     cmd.res_load = 1'b1;
                     state_in     = tcs_pkg::S_DONE;
                  end else if (stat.over) begin
                     cmd.res_load = 1'b1;
                     cmd.res_sel  = tcs_pkg::RES_COUNT;
                     state_in     = tcs_pkg::S_DONE;
                  end else begin
                     cmd.op   = tcs_pkg::OP_SEARCH_START;
                     state_in = tcs_pkg::S_SEARCH;
                  end
               end
               default: state_in = tcs_pkg::S_IDLE;
            endcase
         end
         tcs_pkg::S_READ_WAIT: begin
            cmd.res_load = 1'b1;
            cmd.res_sel  = tcs_pkg::RES_READ;
            state_in     = tcs_pkg::S_DONE;
         end
         tcs_pkg::S_SEARCH: begin
            cmd.op = tcs_pkg::OP_SEARCH_STEP;
            if (stat.step_last) begin
               cmd.res_load = 1'b1;
               cmd.res_sel  = tcs_pkg::RES_BOUND;
               state_in     = tcs_pkg::S_DONE;
            end
         end
         tcs_pkg::S_PROMOTE_RD: begin
            cmd.op   = tcs_pkg::OP_PROMOTE_RD;
            state_in = tcs_pkg::S_PROMOTE_WR;
         end
         tcs_pkg::S_PROMOTE_WR: begin
            cmd.op   = tcs_pkg::OP_PROMOTE_WR;
            state_in = stat.promote_last ? tcs_pkg::S_APPEND_WIDE : tcs_pkg::S_PROMOTE_RD;
         end
         tcs_pkg::S_APPEND_WIDE: begin
            cmd.op       = tcs_pkg::OP_APPEND_WIDE;
            cmd.res_load = 1'b1;
            state_in     = tcs_pkg::S_DONE;
         end
         tcs_pkg::S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.out_load = 1'b1;
               state_in     = tcs_pkg::S_IDLE;
            end
         end
         default: state_in = tcs_pkg::S_IDLE;
      endcase
   end

   assign rsp_valid_in = cmd.out_load | (rsp_valid_ff & ~rsp_tready);
   assign rsp_tvalid   = rsp_valid_ff;

endmodule

// ----- hw/rtl/tcs_datapath.sv -----
// Datapath: stores, base and count registers, search and promotion arithmetic
`timescale 1ns / 1ps
module tcs_datapath (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [tcs_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic [tcs_pkg::FUNC_W-1:0]     req_tuser,
   input  logic                           csr_write,
   input  logic [tcs_pkg::TIME_W-1:0]     csr_wdata,
   input  tcs_pkg::cmd_type               cmd,
   output tcs_pkg::stat_type              stat,
   output logic [tcs_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic [tcs_pkg::STATUS_W-1:0]   rsp_tuser
);

   // latched request
   logic [tcs_pkg::FUNC_W-1:0]      func_ff, func_in;
   logic [tcs_pkg::TIME_W-1:0]      time_ff, time_in;
   logic [tcs_pkg::POS_W-1:0]       pos_ff, pos_in;
   // store state
   logic [tcs_pkg::TIME_W-1:0]      base_ff, base_in;
   logic                            wide_ff, wide_in;
   logic [tcs_pkg::CNT_W-1:0]       count_ff, count_in;
   logic [tcs_pkg::TIME_W-1:0]      marker_ff, marker_in;
   // search and sweep
   logic [tcs_pkg::CNT_W-1:0]       first_ff, first_in;
   logic [tcs_pkg::CNT_W-1:0]       left_ff, left_in;
   logic [tcs_pkg::ADDR_W-1:0]      mid_ff, mid_in;
   logic [tcs_pkg::CNT_W-1:0]       k_ff, k_in;
   // staged result and output register
   logic [tcs_pkg::TIME_W-1:0]      res_time_ff, res_time_in;
   logic [tcs_pkg::IDX_W-1:0]       res_index_ff, res_index_in;
   logic [tcs_pkg::STATUS_W-1:0]    res_status_ff, res_status_in;
   logic [tcs_pkg::TIME_W-1:0]      out_time_ff, out_time_in;
   logic [tcs_pkg::IDX_W-1:0]       out_index_ff, out_index_in;
   logic [tcs_pkg::STATUS_W-1:0]    out_status_ff, out_status_in;

   logic [tcs_pkg::TIME_W-1:0]      diff;
   logic [tcs_pkg::TIME_W-1:0]      off_ext;
   logic [tcs_pkg::TIME_W-1:0]      key;
   logic [tcs_pkg::TIME_W-1:0]      probe;
   logic [tcs_pkg::TIME_W-1:0]      read_time;
   logic                            go_right;
   logic [tcs_pkg::CNT_W-1:0]       half;
   logic [tcs_pkg::CNT_W-1:0]       first_step;
   logic [tcs_pkg::CNT_W-1:0]       left_step;
   logic [tcs_pkg::CNT_W-1:0]       next_mid;
   logic [tcs_pkg::CNT_W-1:0]       count_half;
   logic [tcs_pkg::ADDR_W-1:0]      rd_addr;

   logic                            off_wr_en;
   logic [tcs_pkg::ADDR_W-1:0]      off_wr_addr;
   logic [tcs_pkg::NARROW_BITS-1:0] off_wr_data;
   logic [tcs_pkg::NARROW_BITS-1:0] off_rd_data;
   logic                            abs_wr_en;
   logic [tcs_pkg::ADDR_W-1:0]      abs_wr_addr;
   logic [tcs_pkg::TIME_W-1:0]      abs_wr_data;
   logic [tcs_pkg::TIME_W-1:0]      abs_rd_data;

   tcs_ram #(
      .WIDTH (tcs_pkg::NARROW_BITS),
      .DEPTH (tcs_pkg::DEPTH)
   ) u_offset_ram (
      .clock   (clock),
      .wr_en   (off_wr_en),
      .wr_addr (off_wr_addr),
      .wr_data (off_wr_data),
      .rd_addr (rd_addr),
      .rd_data (off_rd_data)
   );

   tcs_ram #(
      .WIDTH (tcs_pkg::TIME_W),
      .DEPTH (tcs_pkg::DEPTH)
   ) u_absolute_ram (
      .clock   (clock),
      .wr_en   (abs_wr_en),
      .wr_addr (abs_wr_addr),
      .wr_data (abs_wr_data),
      .rd_addr (rd_addr),
      .rd_data (abs_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff   <= '0;
         wide_ff   <= 1'b0;
         count_ff  <= '0;
         marker_ff <= '1;
      end else begin
         base_ff   <= base_in;
         wide_ff   <= wide_in;
         count_ff  <= count_in;
         marker_ff <= marker_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff       <= func_in;
      time_ff       <= time_in;
      pos_ff        <= pos_in;
      first_ff      <= first_in;
      left_ff       <= left_in;
      mid_ff        <= mid_in;
      k_ff          <= k_in;
      res_time_ff   <= res_time_in;
      res_index_ff  <= res_index_in;
      res_status_ff <= res_status_in;
      out_time_ff   <= out_time_in;
      out_index_ff  <= out_index_in;
      out_status_ff <= out_status_in;
   end

   assign diff    = time_ff - base_ff;
   assign off_ext = tcs_pkg::TIME_W'(off_rd_data);

   // one bound-search step on the entry read last cycle
   assign key      = wide_ff ? time_ff : diff;
   assign probe    = wide_ff ? abs_rd_data : off_ext;
   assign go_right = (func_ff == tcs_pkg::FUNC_UPPER) ? !(key < probe) : (probe < key);
   assign half     = left_ff >> 1;
   assign first_step = go_right ? (tcs_pkg::CNT_W'(mid_ff) + tcs_pkg::CNT_W'(1)) : first_ff;
   assign left_step  = go_right ? (left_ff - half - tcs_pkg::CNT_W'(1)) : half;
   assign next_mid   = first_step + (left_step >> 1);
   assign count_half = count_ff >> 1;

   assign read_time = wide_ff ? abs_rd_data : (base_ff + off_ext);

   always_comb begin
      unique case (cmd.op)
         tcs_pkg::OP_READ_ISSUE:   rd_addr = tcs_pkg::ADDR_W'(pos_ff);
         tcs_pkg::OP_SEARCH_START: rd_addr = count_half[tcs_pkg::ADDR_W-1:0];
         tcs_pkg::OP_SEARCH_STEP:  rd_addr = next_mid[tcs_pkg::ADDR_W-1:0];
         tcs_pkg::OP_PROMOTE_RD:   rd_addr = k_ff[tcs_pkg::ADDR_W-1:0];
         default:                  rd_addr = mid_ff;
      endcase
   end

   // offset store writes: first entry (offset zero) and in-range narrow appends
   assign off_wr_en   = (cmd.op == tcs_pkg::OP_APPEND_FIRST) ||
                        (cmd.op == tcs_pkg::OP_APPEND_NARROW);
   assign off_wr_addr = count_ff[tcs_pkg::ADDR_W-1:0];
   assign off_wr_data = (cmd.op == tcs_pkg::OP_APPEND_FIRST) ? '0 :
                        diff[tcs_pkg::NARROW_BITS-1:0];

   // absolute store writes: promotion sweep and wide appends
   assign abs_wr_en   = (cmd.op == tcs_pkg::OP_APPEND_WIDE) ||
                        (cmd.op == tcs_pkg::OP_PROMOTE_WR);
   assign abs_wr_addr = (cmd.op == tcs_pkg::OP_PROMOTE_WR) ? k_ff[tcs_pkg::ADDR_W-1:0] :
                        count_ff[tcs_pkg::ADDR_W-1:0];
   assign abs_wr_data = (cmd.op == tcs_pkg::OP_PROMOTE_WR) ? (base_ff + off_ext) : time_ff;

   always_comb begin
      func_in   = func_ff;
      time_in   = time_ff;
      pos_in    = pos_ff;
      base_in   = base_ff;
      wide_in   = wide_ff;
      count_in  = count_ff;
      marker_in = marker_ff;
      first_in  = first_ff;
      left_in   = left_ff;
      mid_in    = rd_addr;
      k_in      = k_ff;

      if (csr_write) begin
         marker_in = csr_wdata;
      end
      if (cmd.load_req) begin
         func_in = req_tuser;
         time_in = req_tdata[tcs_pkg::TIME_W-1:0];
         pos_in  = req_tdata[tcs_pkg::TIME_W+tcs_pkg::POS_W-1:tcs_pkg::TIME_W];
         k_in    = '0;
      end

      unique case (cmd.op)
         tcs_pkg::OP_APPEND_FIRST: begin
            base_in  = time_ff;
            count_in = count_ff + tcs_pkg::CNT_W'(1);
         end
         tcs_pkg::OP_APPEND_NARROW: count_in = count_ff + tcs_pkg::CNT_W'(1);
         tcs_pkg::OP_APPEND_WIDE: begin
            wide_in  = 1'b1;
            count_in = count_ff + tcs_pkg::CNT_W'(1);
         end
         tcs_pkg::OP_SEARCH_START: begin
            first_in = '0;
            left_in  = count_ff;
         end
         tcs_pkg::OP_SEARCH_STEP: begin
            first_in = first_step;
            left_in  = left_step;
         end
         tcs_pkg::OP_PROMOTE_WR: k_in = k_ff + tcs_pkg::CNT_W'(1);
         default: ;
      endcase
   end

   always_comb begin
      res_time_in   = res_time_ff;
      res_index_in  = res_index_ff;
      res_status_in = res_status_ff;
      if (cmd.res_load) begin
         res_time_in   = '0;
         res_index_in  = '0;
         res_status_in = tcs_pkg::ST_OK;
         unique case (cmd.res_sel)
            tcs_pkg::RES_FULL:     res_status_in = tcs_pkg::ST_FULL;
            tcs_pkg::RES_PAST_END: begin
               res_time_in   = marker_ff;
               res_status_in = tcs_pkg::ST_PAST_END;
            end
            tcs_pkg::RES_READ:     res_time_in  = read_time;
            tcs_pkg::RES_BOUND:    res_index_in = tcs_pkg::IDX_W'(first_step);
            tcs_pkg::RES_COUNT:    res_index_in = tcs_pkg::IDX_W'(count_ff);
            default: ;
         endcase
      end
   end

   assign out_time_in   = cmd.out_load ? res_time_ff   : out_time_ff;
   assign out_index_in  = cmd.out_load ? res_index_ff  : out_index_ff;
   assign out_status_in = cmd.out_load ? res_status_ff : out_status_ff;

   assign rsp_tdata = tcs_pkg::RSP_DATA_W'({out_index_ff, out_time_ff});
   assign rsp_tuser = out_status_ff;

   assign stat.func         = tcs_pkg::func_type'(func_ff);
   assign stat.full         = (count_ff == tcs_pkg::CNT_W'(tcs_pkg::DEPTH));
   assign stat.wide         = wide_ff;
   assign stat.count_zero   = (count_ff == '0);
   assign stat.pos_valid    = (tcs_pkg::CNT_W'(pos_ff) < count_ff);
   assign stat.below_strict = (time_ff < base_ff);
   assign stat.below_eq     = (time_ff <= base_ff);
   assign stat.over         = |(diff >> tcs_pkg::NARROW_BITS);
   assign stat.step_last    = (left_step == '0);
   assign stat.promote_last = ((k_ff + tcs_pkg::CNT_W'(1)) == count_ff);
   assign stat.count        = count_ff;

endmodule
